>>> hw/rtl/stsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stsp_pkg;

	// scanner states
	localparam logic [2:0] ST_SKIP    = 3'd0;
	localparam logic [2:0] ST_SLASH   = 3'd1;
	localparam logic [2:0] ST_COMMENT = 3'd2;
	localparam logic [2:0] ST_QUOTE   = 3'd3;
	localparam logic [2:0] ST_QBACK   = 3'd4;
	localparam logic [2:0] ST_WORD    = 3'd5;

	// token kinds
	localparam logic [1:0] KIND_WORD  = 2'd0;
	localparam logic [1:0] KIND_QUOTE = 2'd1;
	localparam logic [1:0] KIND_DELIM = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       has_byte;
		logic       token_end;
		logic [1:0] token_kind;
		logic       stream_end;
		logic       last;
	} res_t;

	// all results caused by one input byte
	typedef struct packed {
		res_t [MAX_RES-1:0] r;
		logic [1:0]         cnt;
	} ent_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR, CH_APOS, CH_COMMA};
	endfunction

	function automatic res_t mk_res(input logic [7:0] b, input logic has, input logic fin,
		input logic [1:0] kind, input logic send);
		res_t r;
		r.token_byte = b;
		r.has_byte   = has;
		r.token_end  = fin;
		r.token_kind = kind;
		r.stream_end = send;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stsp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stsp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        text_byte,
	input  wire logic              push,
	input  wire logic              q_full,
	output stsp_pkg::ent_t         q_wdata,
	output logic                   q_wr
);

	logic [2:0]     state_q;
	logic [2:0]     nxt;
	logic [2:0]     eff;
	logic           done;
	logic [1:0]     n;
	stsp_pkg::ent_t ent;
	logic           acc;

	assign acc = push && !q_full;

	always_comb begin
		ent  = '0;
		n    = '0;
		nxt  = state_q;
		eff  = state_q;
		done = 1'b0;

		// first step: states that carry a held byte
		if (state_q == stsp_pkg::ST_SLASH) begin
			if (text_byte == stsp_pkg::CH_SLASH) begin
				nxt  = stsp_pkg::ST_COMMENT;
				done = 1'b1;
			end else begin
				ent.r[n] = stsp_pkg::mk_res(stsp_pkg::CH_SLASH, 1'b1, 1'b0,
					stsp_pkg::KIND_WORD, 1'b0);
				n   = n + 2'd1;
				eff = stsp_pkg::ST_WORD;
			end
		end else if (state_q == stsp_pkg::ST_QBACK) begin
			if (text_byte == stsp_pkg::CH_DQUOTE) begin
				ent.r[n] = stsp_pkg::mk_res(stsp_pkg::CH_DQUOTE, 1'b1, 1'b0,
					stsp_pkg::KIND_QUOTE, 1'b0);
				n    = n + 2'd1;
				nxt  = stsp_pkg::ST_QUOTE;
				done = 1'b1;
			end else begin
				ent.r[n] = stsp_pkg::mk_res(stsp_pkg::CH_BSLASH, 1'b1, 1'b0,
					stsp_pkg::KIND_QUOTE, 1'b0);
				n   = n + 2'd1;
				eff = stsp_pkg::ST_QUOTE;
			end
		end

		if (!done) begin
			case (eff)
				stsp_pkg::ST_COMMENT: begin
					if (text_byte == stsp_pkg::CH_NUL) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b0, stsp_pkg::KIND_WORD, 1'b1);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else if (text_byte == stsp_pkg::CH_NL) begin
						nxt = stsp_pkg::ST_SKIP;
					end
				end
				stsp_pkg::ST_QUOTE: begin
					if (text_byte == stsp_pkg::CH_NUL) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b1, stsp_pkg::KIND_QUOTE, 1'b0);
						n = n + 2'd1;
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b0, stsp_pkg::KIND_WORD, 1'b1);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else if (text_byte == stsp_pkg::CH_BSLASH) begin
						nxt = stsp_pkg::ST_QBACK;
					end else if (text_byte == stsp_pkg::CH_DQUOTE) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b1, stsp_pkg::KIND_QUOTE, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else begin
						ent.r[n] = stsp_pkg::mk_res(text_byte, 1'b1, 1'b0,
							stsp_pkg::KIND_QUOTE, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_QUOTE;
					end
				end
				stsp_pkg::ST_WORD: begin
					if (text_byte == stsp_pkg::CH_NUL) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b1, stsp_pkg::KIND_WORD, 1'b0);
						n = n + 2'd1;
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b0, stsp_pkg::KIND_WORD, 1'b1);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else if (text_byte <= stsp_pkg::CH_SPACE) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b1, stsp_pkg::KIND_WORD, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else if (stsp_pkg::is_delim(text_byte)) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b1, stsp_pkg::KIND_WORD, 1'b0);
						n = n + 2'd1;
						ent.r[n] = stsp_pkg::mk_res(text_byte, 1'b1, 1'b1,
							stsp_pkg::KIND_DELIM, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_SKIP;
					end else begin
						ent.r[n] = stsp_pkg::mk_res(text_byte, 1'b1, 1'b0,
							stsp_pkg::KIND_WORD, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_WORD;
					end
				end
				default: begin
					nxt = stsp_pkg::ST_SKIP;
					if (text_byte == stsp_pkg::CH_NUL) begin
						ent.r[n] = stsp_pkg::mk_res('0, 1'b0, 1'b0, stsp_pkg::KIND_WORD, 1'b1);
						n = n + 2'd1;
					end else if (text_byte <= stsp_pkg::CH_SPACE) begin
						nxt = stsp_pkg::ST_SKIP;
					end else if (text_byte == stsp_pkg::CH_SLASH) begin
						nxt = stsp_pkg::ST_SLASH;
					end else if (text_byte == stsp_pkg::CH_DQUOTE) begin
						nxt = stsp_pkg::ST_QUOTE;
					end else if (stsp_pkg::is_delim(text_byte)) begin
						ent.r[n] = stsp_pkg::mk_res(text_byte, 1'b1, 1'b1,
							stsp_pkg::KIND_DELIM, 1'b0);
						n = n + 2'd1;
					end else begin
						ent.r[n] = stsp_pkg::mk_res(text_byte, 1'b1, 1'b0,
							stsp_pkg::KIND_WORD, 1'b0);
						n   = n + 2'd1;
						nxt = stsp_pkg::ST_WORD;
					end
				end
			endcase
		end

		if (n != 2'd0) begin
			ent.r[n - 2'd1].last = 1'b1;
		end
		ent.cnt = n;
	end

	// bytes that cause no result are dropped here
	assign q_wdata = ent;
	assign q_wr    = acc && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stsp_pkg::ST_SKIP;
		end else if (acc) begin
			state_q <= nxt;
		end
	end

`ifndef SYNTH
	a_nul_to_skip: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (text_byte == stsp_pkg::CH_NUL) |=> state_q == stsp_pkg::ST_SKIP)
		else $error("scanner not idle after end of data");
	a_nul_has_send: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (text_byte == stsp_pkg::CH_NUL) |-> q_wr && ent.r[n - 2'd1].stream_end)
		else $error("end of data gave no stream-end word");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/stsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stsp_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire stsp_pkg::ent_t wdata,
	output logic                full,
	input  wire logic           rd,
	output stsp_pkg::ent_t      rdata,
	output logic                nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stsp_pkg::ent_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign rdata    = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= inc(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> nonempty)
		else $error("read from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/stsp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stsp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stsp_pkg::ent_t q_rdata,
	input  wire logic           q_nonempty,
	output logic                q_rd,
	output stsp_pkg::res_t      out_data,
	output logic                empty,
	input  wire logic           pop
);

	logic [1:0]     idx_q;
	logic           ovalid_q;
	stsp_pkg::res_t out_q;
	logic           load;
	logic           at_end;

	assign load   = q_nonempty && (!ovalid_q || pop);
	assign at_end = idx_q == (q_rdata.cnt - 2'd1);
	assign q_rd   = load && at_end;

	assign out_data = out_q;
	assign empty    = !ovalid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= q_rdata.r[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_nonempty |-> idx_q < q_rdata.cnt)
		else $error("result index beyond queued entry");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/script_token_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// Script tokenizer: text bytes in, token bytes and markers out.
// Input queue side: drive text_byte with push; the byte is taken on a clock
// edge where push is high and full is low. A zero byte ends the data.
// Output queue side: while empty is low, token_byte/has_byte/token_end/
// token_kind/stream_end/last show the oldest result; pop on an edge with
// empty low takes it. last flags the final result of one input byte.
// Each input byte gives zero to three results. The scanner decides all of
// them in the cycle the byte is taken and writes them as one entry into a
// DEPTH-entry queue; the output stage hands them out one per cycle while pop
// is high. A result passes through the queue and the output register before
// it shows on the ports. Throughput: one byte per cycle while bytes give at
// most one result each and pop stays high; otherwise the output stage sets
// the pace, and full rises once the queue fills.
// When the receiver holds pop low the output register holds its word and
// the queue absorbs further entries until full.
// Reset clears the scanner to skipping whitespace and empties the queue and
// the output register.
module script_token_splitter #(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       push,
	output logic            full,
	output logic [7:0]      token_byte,
	output logic            has_byte,
	output logic            token_end,
	output logic [1:0]      token_kind,
	output logic            stream_end,
	output logic            last,
	output logic            empty,
	input  wire logic       pop
);

	stsp_pkg::ent_t q_wdata;
	stsp_pkg::ent_t q_rdata;
	stsp_pkg::res_t out_data;
	logic           q_wr;
	logic           q_rd;
	logic           q_nonempty;

	stsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (text_byte),
		.push      (push),
		.q_full    (full),
		.q_wdata   (q_wdata),
		.q_wr      (q_wr)
	);

	stsp_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.full     (full),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	stsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rdata    (q_rdata),
		.q_nonempty (q_nonempty),
		.q_rd       (q_rd),
		.out_data   (out_data),
		.empty      (empty),
		.pop        (pop)
	);

	assign token_byte = out_data.token_byte;
	assign has_byte   = out_data.has_byte;
	assign token_end  = out_data.token_end;
	assign token_kind = out_data.token_kind;
	assign stream_end = out_data.stream_end;
	assign last       = out_data.last;

endmodule

`default_nettype wire

>>> dv/script_token_checker.sv
`timescale 1ns / 1ps

module script_token_checker
	import stsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       push,
	input  wire logic       full,
	input  wire logic [7:0] token_byte,
	input  wire logic       has_byte,
	input  wire logic       token_end,
	input  wire logic [1:0] token_kind,
	input  wire logic       stream_end,
	input  wire logic       last,
	input  wire logic       empty,
	input  wire logic       pop,
	output int              fails,
	output int              pending
);

	logic [2:0] scan_st;
	res_t       awaited_words[$];
	res_t       fresh_words[$];
	int         miss_count;

	function automatic logic splits_word(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAR || c == CH_RPAR ||
			c == CH_APOS || c == CH_COMMA;
	endfunction

	task automatic emit(input logic [7:0] b, input logic has, input logic fin,
		input logic [1:0] kind, input logic send);
		res_t w;
		w.token_byte = b;
		w.has_byte   = has;
		w.token_end  = fin;
		w.token_kind = kind;
		w.stream_end = send;
		w.last       = 1'b0;
		fresh_words.push_back(w);
	endtask

	task automatic close_stream();
		emit(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
		scan_st = ST_SKIP;
	endtask

	// byte that extends or terminates an open word
	task automatic word_step(input logic [7:0] c);
		if (c == CH_NUL) begin
			emit(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
			close_stream();
		end else if (c <= CH_SPACE) begin
			emit(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
			scan_st = ST_SKIP;
		end else if (splits_word(c)) begin
			emit(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
			emit(c, 1'b1, 1'b1, KIND_DELIM, 1'b0);
			scan_st = ST_SKIP;
		end else begin
			emit(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
			scan_st = ST_WORD;
		end
	endtask

	// byte inside an open quoted string
	task automatic string_step(input logic [7:0] c);
		if (c == CH_NUL) begin
			emit(CH_NUL, 1'b0, 1'b1, KIND_QUOTE, 1'b0);
			close_stream();
		end else if (c == CH_BSLASH) begin
			scan_st = ST_QBACK;
		end else if (c == CH_DQUOTE) begin
			emit(CH_NUL, 1'b0, 1'b1, KIND_QUOTE, 1'b0);
			scan_st = ST_SKIP;
		end else begin
			emit(c, 1'b1, 1'b0, KIND_QUOTE, 1'b0);
			scan_st = ST_QUOTE;
		end
	endtask

	task automatic scan_byte(input logic [7:0] c);
		res_t tail;
		fresh_words.delete();
		case (scan_st)
			ST_SLASH: begin
				if (c == CH_SLASH) begin
					scan_st = ST_COMMENT;
				end else begin
					emit(CH_SLASH, 1'b1, 1'b0, KIND_WORD, 1'b0);
					word_step(c);
				end
			end
			ST_COMMENT: begin
				if (c == CH_NUL)
					close_stream();
				else if (c == CH_NL)
					scan_st = ST_SKIP;
			end
			ST_QUOTE: string_step(c);
			ST_QBACK: begin
				if (c == CH_DQUOTE) begin
					emit(CH_DQUOTE, 1'b1, 1'b0, KIND_QUOTE, 1'b0);
					scan_st = ST_QUOTE;
				end else begin
					emit(CH_BSLASH, 1'b1, 1'b0, KIND_QUOTE, 1'b0);
					string_step(c);
				end
			end
			ST_WORD: word_step(c);
			default: begin
				if (c == CH_NUL) begin
					close_stream();
				end else if (c <= CH_SPACE) begin
					scan_st = ST_SKIP;
				end else if (c == CH_SLASH) begin
					scan_st = ST_SLASH;
				end else if (c == CH_DQUOTE) begin
					scan_st = ST_QUOTE;
				end else if (splits_word(c)) begin
					emit(c, 1'b1, 1'b1, KIND_DELIM, 1'b0);
					scan_st = ST_SKIP;
				end else begin
					emit(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
					scan_st = ST_WORD;
				end
			end
		endcase
		// flag the final word of this byte
		if (fresh_words.size() > 0) begin
			tail = fresh_words.pop_back();
			tail.last = 1'b1;
			fresh_words.push_back(tail);
		end
		foreach (fresh_words[i])
			awaited_words.push_back(fresh_words[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t seen;
		if (!arst_n) begin
			scan_st = ST_SKIP;
			awaited_words.delete();
			miss_count = 0;
			fails   <= 0;
			pending <= 0;
		end else begin
			// retire the output word before taking the new input byte
			if (pop && !empty) begin
				seen.token_byte = token_byte;
				seen.has_byte   = has_byte;
				seen.token_end  = token_end;
				seen.token_kind = token_kind;
				seen.stream_end = stream_end;
				seen.last       = last;
				if (awaited_words.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("%0t: unexpected word byte=%02h has=%0b end=%0b kind=%0d send=%0b last=%0b",
							$realtime, seen.token_byte, seen.has_byte, seen.token_end,
							seen.token_kind, seen.stream_end, seen.last);
				end else begin
					want = awaited_words.pop_front();
					if (seen.token_byte !== want.token_byte || seen.has_byte !== want.has_byte ||
						seen.token_end !== want.token_end || seen.token_kind !== want.token_kind ||
						seen.stream_end !== want.stream_end || seen.last !== want.last) begin
						miss_count++;
						if (miss_count <= 10)
							$display("%0t: mismatch exp byte=%02h has=%0b end=%0b kind=%0d send=%0b last=%0b, got byte=%02h has=%0b end=%0b kind=%0d send=%0b last=%0b",
								$realtime, want.token_byte, want.has_byte, want.token_end,
								want.token_kind, want.stream_end, want.last,
								seen.token_byte, seen.has_byte, seen.token_end,
								seen.token_kind, seen.stream_end, seen.last);
					end
				end
			end
			if (push && !full)
				scan_byte(text_byte);
			fails   <= miss_count;
			pending <= awaited_words.size();
		end
	end

endmodule

>>> dv/tb_script_token_splitter.sv
`timescale 1ns / 1ps

module tb_script_token_splitter;
	import stsp_pkg::*;

	logic       clk;
	logic       arst_n;
	logic [7:0] text_byte;
	logic       push;
	logic       full;
	logic [7:0] token_byte;
	logic       has_byte;
	logic       token_end;
	logic [1:0] token_kind;
	logic       stream_end;
	logic       last;
	logic       empty;
	logic       pop;
	int         fails;
	int         pending;
	int         n_items;
	bit         calm;

	script_token_splitter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.push       (push),
		.full       (full),
		.token_byte (token_byte),
		.has_byte   (has_byte),
		.token_end  (token_end),
		.token_kind (token_kind),
		.stream_end (stream_end),
		.last       (last),
		.empty      (empty),
		.pop        (pop)
	);

	script_token_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.push       (push),
		.full       (full),
		.token_byte (token_byte),
		.has_byte   (has_byte),
		.token_end  (token_end),
		.token_kind (token_kind),
		.stream_end (stream_end),
		.last       (last),
		.empty      (empty),
		.pop        (pop),
		.fails      (fails),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		pop = calm || ($urandom_range(99) >= 30);
	end

	initial begin
		#2_000_000;
		$display("script_token_splitter test failed");
		$finish;
	end

	function automatic logic is_separator(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAR || c == CH_RPAR ||
			c == CH_APOS || c == CH_COMMA;
	endfunction

	// offer one byte, hold it until taken; returns at the following falling edge
	task automatic send_byte(input logic [7:0] b, input bit counted);
		while (!calm && $urandom_range(99) < 30) begin
			push = 1'b0;
			@(negedge clk);
		end
		push      = 1'b1;
		text_byte = b;
		do begin
			@(posedge clk);
		end while (full);
		@(negedge clk);
		if (counted)
			n_items++;
	endtask

	function automatic logic [7:0] word_char(input bit opening);
		logic [7:0] c;
		c = 8'($urandom_range(33, 255));
		// push delimiters and token openers up into the high half
		if (is_separator(c) || (opening && (c == CH_SLASH || c == CH_DQUOTE)))
			c = c | 8'h80;
		return c;
	endfunction

	task automatic send_word();
		int len;
		len = $urandom_range(1, 8);
		send_byte(word_char(1'b1), 1'b1);
		for (int i = 1; i < len; i++)
			send_byte(word_char(1'b0), 1'b1);
	endtask

	task automatic send_quoted();
		int         len;
		logic [7:0] c;
		len = $urandom_range(0, 6);
		send_byte(CH_DQUOTE, 1'b1);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: begin
					send_byte(CH_BSLASH, 1'b1);
					send_byte(CH_DQUOTE, 1'b1);
				end
				1: send_byte(CH_BSLASH, 1'b1);
				default: begin
					c = 8'($urandom_range(1, 255));
					if (c == CH_DQUOTE)
						c = 8'h71;
					send_byte(c, 1'b1);
				end
			endcase
		end
		// leave some strings open at end of data
		send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_DQUOTE, 1'b1);
	endtask

	task automatic send_comment();
		int         len;
		logic [7:0] c;
		len = $urandom_range(0, 8);
		send_byte(CH_SLASH, 1'b1);
		send_byte(CH_SLASH, 1'b1);
		for (int i = 0; i < len; i++) begin
			c = 8'($urandom_range(1, 255));
			if (c == CH_NL)
				c = 8'h8A;
			send_byte(c, 1'b1);
		end
		send_byte(($urandom_range(6) == 0) ? CH_NUL : CH_NL, 1'b1);
	endtask

	task automatic send_delim();
		logic [7:0] c;
		case ($urandom_range(5))
			0: c = CH_LBRACE;
			1: c = CH_RBRACE;
			2: c = CH_LPAR;
			3: c = CH_RPAR;
			4: c = CH_APOS;
			default: c = CH_COMMA;
		endcase
		send_byte(c, 1'b1);
	endtask

	task automatic send_gap();
		int len;
		len = $urandom_range(1, 3);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(1, 32)), 1'b1);
	endtask

	logic [7:0] opening_text [27];
	int         pick;

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		text_byte = CH_NUL;
		push      = 1'b0;
		pop       = 1'b0;
		calm      = 1'b0;
		n_items   = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// word with top-bit bytes, every delimiter, whitespace extremes, strings with
		// escapes and open at end of data, lone slash, comment and backslash cut by end of data
		opening_text = '{8'h61, 8'hFF, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_APOS,
			CH_COMMA, CH_SPACE, 8'h80, CH_NUL, CH_DQUOTE, CH_DQUOTE, CH_DQUOTE, CH_BSLASH,
			CH_DQUOTE, CH_BSLASH, 8'h7E, CH_NUL, CH_SLASH, 8'h01, CH_SLASH, CH_SLASH, CH_NUL,
			CH_DQUOTE, CH_BSLASH, CH_NUL};
		foreach (opening_text[i])
			send_byte(opening_text[i], 1'b1);

		n_items = 0;
		while (n_items < 430) begin
			calm = (n_items >= 180 && n_items < 300);
			pick = $urandom_range(99);
			if (pick < 28) begin
				send_word();
			end else if (pick < 42) begin
				send_quoted();
			end else if (pick < 52) begin
				send_delim();
			end else if (pick < 60) begin
				send_comment();
			end else if (pick < 66) begin
				// lone slash, then whatever comes
				send_byte(CH_SLASH, 1'b1);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 71) begin
				send_byte(CH_NUL, 1'b1);
			end else if (pick < 86) begin
				send_gap();
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		end
		calm = 1'b0;
		push = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("script_token_splitter test passed");
		else
			$display("script_token_splitter test failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/stsp_pkg.sv
hw/rtl/stsp_front.sv
hw/rtl/stsp_fifo.sv
hw/rtl/stsp_back.sv
hw/rtl/script_token_splitter.sv
dv/script_token_checker.sv
dv/tb_script_token_splitter.sv
